[hdl/acr_pkg.sv]
// ----------------------------------------------------------------------------
// acr_pkg
// Shared types and constants of the associative cache with replacement.
// ----------------------------------------------------------------------------
package acr_pkg;

   localparam int KEY_BITS        = 31;
   localparam int OUT_HANDLE_BITS = 32;
   localparam int SLOT_BITS       = 4;
   localparam int KIND_BITS       = 2;
   localparam int MODE_BITS       = 2;
   localparam int LFSR_BITS       = 16;
   localparam int CSR_INDEX_BITS  = 1;
   localparam int CSR_DATA_BITS   = 16;

   // Request kinds.
   localparam logic [KIND_BITS-1:0] KIND_LOOKUP = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_INSERT = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_FLUSH  = 2'd2;

   // Replacement modes. Any code other than FIFO and random behaves as LRU.
   localparam logic [MODE_BITS-1:0] MODE_FIFO   = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_LRU    = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_RANDOM = 2'd2;

   // Register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_REPLACE_MODE = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RANDOM_SEED  = 1'd1;

   localparam logic [LFSR_BITS-1:0] LFSR_RESET = 16'hACE1;
   localparam logic [LFSR_BITS-1:0] LFSR_ONE   = 16'h0001;

   // Reciprocal used to reduce the LFSR value modulo the entry count.
   localparam int RECIP_SHIFT = 22;

   typedef enum logic [2:0] {
      CTL_IDLE,
      CTL_SEARCH,
      CTL_RAND_MUL,
      CTL_RAND_MOD,
      CTL_RESULT
   } ctl_state_type;

   typedef struct packed {
      logic capture;
      logic search;
      logic rand_mul;
      logic rand_mod;
      logic finish;
   } ctl_cmd_type;

   typedef struct packed {
      logic need_random;
   } dp_status_type;

endpackage

[hdl/acr_ram.sv]
// ----------------------------------------------------------------------------
// acr_ram
// Generic single-port-address RAM with registered, read-first read data.
// ----------------------------------------------------------------------------
module acr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/acr_ctrl.sv]
// ----------------------------------------------------------------------------
// acr_ctrl
// Sequencer: accepts requests, steps the datapath through search, optional
// random-victim reduction and result load, and owns the result valid flag.
// ----------------------------------------------------------------------------
module acr_ctrl
   import acr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   input  dp_status_type status,
   output ctl_cmd_type   cmd
);

   ctl_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          can_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CTL_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign can_load = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         CTL_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = CTL_SEARCH;
            end
         end
         CTL_SEARCH: begin
            cmd.search = 1'b1;
            state_in   = status.need_random ? CTL_RAND_MUL : CTL_RESULT;
         end
         CTL_RAND_MUL: begin
            cmd.rand_mul = 1'b1;
            state_in     = CTL_RAND_MOD;
         end
         CTL_RAND_MOD: begin
            cmd.rand_mod = 1'b1;
            state_in     = CTL_RESULT;
         end
         CTL_RESULT: begin
            // The next request may enter in the same cycle the result loads.
            if (can_load) begin
               cmd.finish = 1'b1;
               req_stall  = 1'b0;
               if (req_valid) begin
                  cmd.capture = 1'b1;
                  state_in    = CTL_SEARCH;
               end else begin
                  state_in = CTL_IDLE;
               end
            end
         end
         default: begin
            state_in = CTL_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[hdl/acr_datapath.sv]
// ----------------------------------------------------------------------------
// acr_datapath
// Entry lanes (valid, key, recency rank), the key/handle RAM, victim
// selection, the replacement LFSR and the result registers.
// ----------------------------------------------------------------------------
module acr_datapath
   import acr_pkg::*;
#(
   parameter int ENTRIES     = 16,
   parameter int HANDLE_BITS = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  ctl_cmd_type                cmd,
   output dp_status_type              status,
   input  logic                       csr_write,
   input  logic [CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0]   csr_data,
   input  logic [KIND_BITS-1:0]       req_kind,
   input  logic [KEY_BITS-1:0]        req_key,
   input  logic [OUT_HANDLE_BITS-1:0] req_handle,
   output logic                       rsp_hit,
   output logic [SLOT_BITS-1:0]       rsp_slot,
   output logic [OUT_HANDLE_BITS-1:0] rsp_found_handle,
   output logic                       rsp_evicted,
   output logic [KEY_BITS-1:0]        rsp_evicted_key,
   output logic [OUT_HANDLE_BITS-1:0] rsp_evicted_handle
);

   localparam int IDX_BITS    = $clog2(ENTRIES);
   localparam int RAM_WIDTH   = KEY_BITS + HANDLE_BITS;
   localparam int RECIP_MULT  = (1 << RECIP_SHIFT) / ENTRIES;
   localparam int PROD_BITS   = LFSR_BITS + RECIP_SHIFT;
   localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(ENTRIES - 1);

   // Request registers.
   logic [KIND_BITS-1:0]   kind_ff, kind_in;
   logic [KEY_BITS-1:0]    key_ff, key_in;
   logic [HANDLE_BITS-1:0] handle_ff, handle_in;

   // Entry lanes.
   logic [ENTRIES-1:0]     valid_ff, valid_in;
   logic [KEY_BITS-1:0]    key_lane_ff [ENTRIES];
   logic [KEY_BITS-1:0]    key_lane_in [ENTRIES];
   logic [IDX_BITS-1:0]    rank_ff [ENTRIES];
   logic [IDX_BITS-1:0]    rank_in [ENTRIES];
   logic [IDX_BITS-1:0]    fifo_ff, fifo_in;
   logic [LFSR_BITS-1:0]   lfsr_ff, lfsr_in;
   logic [MODE_BITS-1:0]   mode_ff, mode_in;

   // Outcome of the search / commit step.
   logic                   hit_ff, hit_in;
   logic                   evict_ff, evict_in;
   logic                   touch_ff, touch_in;
   logic [IDX_BITS-1:0]    idx_ff, idx_in;
   logic [LFSR_BITS-1:0]   quot_ff, quot_in;

   // Result registers.
   logic                       rsp_hit_ff, rsp_hit_in;
   logic [SLOT_BITS-1:0]       rsp_slot_ff, rsp_slot_in;
   logic [OUT_HANDLE_BITS-1:0] rsp_found_ff, rsp_found_in;
   logic                       rsp_evicted_ff, rsp_evicted_in;
   logic [KEY_BITS-1:0]        rsp_ev_key_ff, rsp_ev_key_in;
   logic [OUT_HANDLE_BITS-1:0] rsp_ev_handle_ff, rsp_ev_handle_in;

   // Search logic.
   logic [ENTRIES-1:0]     match;
   logic                   hit_any;
   logic [IDX_BITS-1:0]    hit_idx;
   logic                   empty_any;
   logic [IDX_BITS-1:0]    empty_idx;
   logic [IDX_BITS-1:0]    lru_idx;
   logic [IDX_BITS-1:0]    victim_idx;
   logic                   need_random;
   logic                   commit;
   logic [IDX_BITS-1:0]    commit_idx;
   logic                   lookup_hit;
   logic [LFSR_BITS-1:0]   lfsr_next;
   logic [PROD_BITS-1:0]   recip_prod;
   logic [PROD_BITS-1:0]   quot_times_n;
   logic [LFSR_BITS-1:0]   rem_raw;
   logic [LFSR_BITS-1:0]   rem_fix;
   logic [IDX_BITS-1:0]    rand_idx;
   logic [IDX_BITS-1:0]    touched_rank;
   logic [63:0]            req_handle_wide;
   logic [63:0]            rd_handle_wide;

   // RAM interface.
   logic                   ram_wr_en;
   logic                   ram_rd_en;
   logic [IDX_BITS-1:0]    ram_addr;
   logic [RAM_WIDTH-1:0]   ram_rd_data;
   logic [KEY_BITS-1:0]    rd_key;
   logic [HANDLE_BITS-1:0] rd_handle;

   acr_ram #(
      .WIDTH (RAM_WIDTH),
      .DEPTH (ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .rd_en   (ram_rd_en),
      .addr    (ram_addr),
      .wr_data ({key_ff, handle_ff}),
      .rd_data (ram_rd_data)
   );

   assign rd_key         = ram_rd_data[RAM_WIDTH-1:HANDLE_BITS];
   assign rd_handle      = ram_rd_data[HANDLE_BITS-1:0];
   assign rd_handle_wide = 64'(rd_handle);
   assign req_handle_wide = 64'(req_handle);

   // Compare lanes and priority encoders; the lowest index wins.
   always_comb begin
      hit_any   = 1'b0;
      hit_idx   = '0;
      empty_any = 1'b0;
      empty_idx = '0;
      lru_idx   = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         match[i] = valid_ff[i] && (key_lane_ff[i] == key_ff);
         if (match[i]) begin
            hit_any = 1'b1;
            hit_idx = IDX_BITS'(i);
         end
         if (!valid_ff[i]) begin
            empty_any = 1'b1;
            empty_idx = IDX_BITS'(i);
         end
         // Ranks form a permutation, so exactly one entry holds rank zero.
         if (rank_ff[i] == '0) begin
            lru_idx = IDX_BITS'(i);
         end
      end
   end

   always_comb begin
      if (mode_ff == MODE_FIFO) begin
         victim_idx = fifo_ff;
      end else if (empty_any) begin
         victim_idx = empty_idx;
      end else begin
         victim_idx = lru_idx;
      end
   end

   assign need_random = (kind_ff == KIND_INSERT) && (mode_ff == MODE_RANDOM) && !empty_any;
   assign status.need_random = need_random;

   assign lfsr_next = {lfsr_ff[14:0], lfsr_ff[15] ^ lfsr_ff[13] ^ lfsr_ff[12] ^ lfsr_ff[10]};

   // Remainder of the LFSR value by the entry count: reciprocal estimate of
   // the quotient (never high, at most one low), then one correction.
   assign recip_prod   = PROD_BITS'(lfsr_ff) * PROD_BITS'(RECIP_MULT);
   assign quot_times_n = PROD_BITS'(quot_ff) * PROD_BITS'(ENTRIES);
   assign rem_raw      = lfsr_ff - quot_times_n[LFSR_BITS-1:0];
   assign rem_fix      = (rem_raw >= LFSR_BITS'(ENTRIES)) ?
                         rem_raw - LFSR_BITS'(ENTRIES) : rem_raw;
   assign rand_idx     = rem_fix[IDX_BITS-1:0];

   assign commit     = (cmd.search && (kind_ff == KIND_INSERT) && !need_random) ||
                       cmd.rand_mod;
   assign commit_idx = cmd.rand_mod ? rand_idx : victim_idx;
   assign lookup_hit = cmd.search && (kind_ff == KIND_LOOKUP) && hit_any;

   assign ram_wr_en = commit;
   assign ram_rd_en = commit || lookup_hit;
   assign ram_addr  = commit ? commit_idx : hit_idx;

   assign touched_rank = rank_ff[idx_ff];

   always_comb begin
      kind_in     = kind_ff;
      key_in      = key_ff;
      handle_in   = handle_ff;
      valid_in    = valid_ff;
      key_lane_in = key_lane_ff;
      rank_in     = rank_ff;
      fifo_in     = fifo_ff;
      lfsr_in     = lfsr_ff;
      mode_in     = mode_ff;
      hit_in      = hit_ff;
      evict_in    = evict_ff;
      touch_in    = touch_ff;
      idx_in      = idx_ff;
      quot_in     = quot_ff;

      rsp_hit_in       = rsp_hit_ff;
      rsp_slot_in      = rsp_slot_ff;
      rsp_found_in     = rsp_found_ff;
      rsp_evicted_in   = rsp_evicted_ff;
      rsp_ev_key_in    = rsp_ev_key_ff;
      rsp_ev_handle_in = rsp_ev_handle_ff;

      if (cmd.capture) begin
         kind_in   = req_kind;
         key_in    = req_key;
         handle_in = req_handle_wide[HANDLE_BITS-1:0];
      end

      if (cmd.search) begin
         hit_in   = 1'b0;
         evict_in = 1'b0;
         touch_in = 1'b0;
         case (kind_ff)
            KIND_LOOKUP: begin
               if (hit_any) begin
                  hit_in   = 1'b1;
                  touch_in = 1'b1;
                  idx_in   = hit_idx;
               end
            end
            KIND_INSERT: begin
               if (need_random) begin
                  lfsr_in = lfsr_next;
               end
            end
            KIND_FLUSH: begin
               valid_in = '0;
               fifo_in  = '0;
               for (int i = 0; i < ENTRIES; i++) begin
                  rank_in[i] = IDX_BITS'(i);
               end
            end
            default: begin
            end
         endcase
      end

      if (cmd.rand_mul) begin
         quot_in = recip_prod[PROD_BITS-1:RECIP_SHIFT];
      end

      if (commit) begin
         evict_in                = valid_ff[commit_idx];
         touch_in                = 1'b1;
         hit_in                  = 1'b0;
         idx_in                  = commit_idx;
         valid_in[commit_idx]    = 1'b1;
         key_lane_in[commit_idx] = key_ff;
         if (mode_ff == MODE_FIFO) begin
            fifo_in = (commit_idx == LAST_IDX) ? '0 : commit_idx + 1'b1;
         end
      end

      if (cmd.finish) begin
         // Move the touched entry to most recently used; close the gap.
         if (touch_ff) begin
            for (int i = 0; i < ENTRIES; i++) begin
               if (rank_ff[i] > touched_rank) begin
                  rank_in[i] = rank_ff[i] - 1'b1;
               end
            end
            rank_in[idx_ff] = LAST_IDX;
         end
         rsp_hit_in       = hit_ff;
         rsp_slot_in      = touch_ff ? SLOT_BITS'(idx_ff) : '0;
         rsp_found_in     = hit_ff ? rd_handle_wide[OUT_HANDLE_BITS-1:0] : '0;
         rsp_evicted_in   = evict_ff;
         rsp_ev_key_in    = evict_ff ? rd_key : '0;
         rsp_ev_handle_in = evict_ff ? rd_handle_wide[OUT_HANDLE_BITS-1:0] : '0;
      end

      if (csr_write) begin
         unique case (csr_index)
            CSR_REPLACE_MODE: mode_in = csr_data[MODE_BITS-1:0];
            CSR_RANDOM_SEED:  lfsr_in = (csr_data == '0) ? LFSR_ONE : csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         fifo_ff  <= '0;
         lfsr_ff  <= LFSR_RESET;
         mode_ff  <= MODE_FIFO;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= IDX_BITS'(i);
         end
      end else begin
         valid_ff <= valid_in;
         fifo_ff  <= fifo_in;
         lfsr_ff  <= lfsr_in;
         mode_ff  <= mode_in;
         rank_ff  <= rank_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff          <= kind_in;
      key_ff           <= key_in;
      handle_ff        <= handle_in;
      key_lane_ff      <= key_lane_in;
      hit_ff           <= hit_in;
      evict_ff         <= evict_in;
      touch_ff         <= touch_in;
      idx_ff           <= idx_in;
      quot_ff          <= quot_in;
      rsp_hit_ff       <= rsp_hit_in;
      rsp_slot_ff      <= rsp_slot_in;
      rsp_found_ff     <= rsp_found_in;
      rsp_evicted_ff   <= rsp_evicted_in;
      rsp_ev_key_ff    <= rsp_ev_key_in;
      rsp_ev_handle_ff <= rsp_ev_handle_in;
   end

   assign rsp_hit            = rsp_hit_ff;
   assign rsp_slot           = rsp_slot_ff;
   assign rsp_found_handle   = rsp_found_ff;
   assign rsp_evicted        = rsp_evicted_ff;
   assign rsp_evicted_key    = rsp_ev_key_ff;
   assign rsp_evicted_handle = rsp_ev_handle_ff;

endmodule

[hdl/assoc_cache_with_replacement.sv]
// A result passes the search and result states, then is registered; an insert in
// random mode into a full store also passes the multiply and reduce states of the
// two-step remainder. A new request is taken only while idle or as the previous
// result loads; the search/commit step and registered entry RAM read set the pace.
// Reset is synchronous: valid bits clear, ranks return to index order, FIFO pointer
// and mode go to zero, the LFSR loads 0xACE1; no clearing pass is needed.
// ----------------------------------------------------------------------------
// assoc_cache_with_replacement
// Fully associative key/handle store with FIFO, LRU or random replacement.
// ----------------------------------------------------------------------------
module assoc_cache_with_replacement
   import acr_pkg::*;
#(
   parameter int ENTRIES     = 16,
   parameter int HANDLE_BITS = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write,
   input  logic [CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0]   csr_data,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [KIND_BITS-1:0]       req_kind,
   input  logic [KEY_BITS-1:0]        req_key,
   input  logic [OUT_HANDLE_BITS-1:0] req_handle,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_hit,
   output logic [SLOT_BITS-1:0]       rsp_slot,
   output logic [OUT_HANDLE_BITS-1:0] rsp_found_handle,
   output logic                       rsp_evicted,
   output logic [KEY_BITS-1:0]        rsp_evicted_key,
   output logic [OUT_HANDLE_BITS-1:0] rsp_evicted_handle
);

   ctl_cmd_type   cmd;
   dp_status_type status;

   acr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   acr_datapath #(
      .ENTRIES     (ENTRIES),
      .HANDLE_BITS (HANDLE_BITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .req_kind           (req_kind),
      .req_key            (req_key),
      .req_handle         (req_handle),
      .rsp_hit            (rsp_hit),
      .rsp_slot           (rsp_slot),
      .rsp_found_handle   (rsp_found_handle),
      .rsp_evicted        (rsp_evicted),
      .rsp_evicted_key    (rsp_evicted_key),
      .rsp_evicted_handle (rsp_evicted_handle)
   );

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the associative cache with replacement. A short
// table of directed requests and register writes runs first, then random
// phases of lookups, inserts and flushes under each replacement mode and
// several LFSR seeds. Each response is checked against its typed table row
// or a cycle-free model of the entry store, recency order, FIFO pointer and LFSR.
// ----------------------------------------------------------------------------
module tb;
   import acr_pkg::*;

   localparam int NUM_ENTRIES   = 16;
   localparam int CLOCK_HALF    = 10;
   localparam int RESET_CYCLES  = 12;
   localparam int QUIET_LIMIT   = 1000;
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_PHASES = 14;
   localparam int PHASE_ITEMS   = 102;
   localparam int REPORT_LIMIT  = 10;
   localparam int ROW_COUNT     = 25;

   localparam logic [KIND_BITS-1:0] KIND_UNUSED    = 2'd3;
   localparam logic [MODE_BITS-1:0] MODE_LRU_ALIAS = 2'd3;
   localparam logic [KEY_BITS-1:0]  KEY_MAX        = '1;
   localparam logic [LFSR_BITS-1:0] SEED_ZERO      = 16'h0000;
   localparam logic [LFSR_BITS-1:0] SEED_MAX       = 16'hFFFF;

   typedef struct packed {
      logic                       hit;
      logic [SLOT_BITS-1:0]       slot;
      logic [OUT_HANDLE_BITS-1:0] found_handle;
      logic                       evicted;
      logic [KEY_BITS-1:0]        evicted_key;
      logic [OUT_HANDLE_BITS-1:0] evicted_handle;
   } cache_result_type;

   typedef enum logic {ROW_REQ, ROW_CSR} row_op_type;

   typedef struct packed {
      row_op_type                 op;
      logic [CSR_INDEX_BITS-1:0]  csr_sel;
      logic [CSR_DATA_BITS-1:0]   csr_value;
      logic [KIND_BITS-1:0]       kind;
      logic [KEY_BITS-1:0]        key;
      logic [OUT_HANDLE_BITS-1:0] handle;
      logic                       typed;
      cache_result_type           want;
   } stim_row_type;

   localparam cache_result_type NO_RESULT = '0;

   // Rows with typed set carry a response that follows directly from the
   // reset state; the rest are checked against the model.
   localparam stim_row_type DIRECTED_ROWS [ROW_COUNT] = '{
      '{ROW_REQ, CSR_REPLACE_MODE, '0, KIND_LOOKUP, '0, '0, 1'b1, NO_RESULT},
      '{ROW_REQ, CSR_REPLACE_MODE, '0, KIND_LOOKUP, KEY_MAX, '1, 1'b1, NO_RESULT},
      '{ROW_REQ, CSR_REPLACE_MODE, '0, KIND_INSERT, '0, '0, 1'b1,
        '{1'b0, 4'd0, 32'd0, 1'b0, 31'd0, 32'd0}},
      '{ROW_REQ, CSR_REPLACE_MODE, '0, KIND_INSERT, KEY_MAX, 32'hFFFF_FFFF, 1'b1,
        '{1'b0, 4'd1, 32'd0, 1'b0, 31'd0, 32'd0}},
      '{ROW_REQ, CSR_REPLACE_MODE, '0, KIND_LOOKUP, KEY_MAX, '0, 1'b1,
        '{1'b1, 4'd1, 32'hFFFF_FFFF, 1'b0, 31'd0, 32'd0}},
      '{ROW_REQ, CSR_REPLACE_MODE, '0, KIND_LOOKUP, '0, '1, 1'b1,
        '{1'b1, 4'd0, 32'd0, 1'b0, 31'd0, 32'd0}},
      '{ROW_REQ, CSR_REPLACE_MODE, '0, KIND_INSERT, KEY_MAX, 32'h1234_5678, 1'b1,
        '{1'b0, 4'd2, 32'd0, 1'b0, 31'd0, 32'd0}},
      // The duplicate key must report the lower slot.
      '{ROW_REQ, CSR_REPLACE_MODE, '0, KIND_LOOKUP, KEY_MAX, '0, 1'b1,
        '{1'b1, 4'd1, 32'hFFFF_FFFF, 1'b0, 31'd0, 32'd0}},
      '{ROW_REQ, CSR_REPLACE_MODE, '0, KIND_UNUSED, KEY_MAX, '1, 1'b1, NO_RESULT},
      '{ROW_REQ, CSR_REPLACE_MODE, '0, KIND_LOOKUP, '0, '0, 1'b1,
        '{1'b1, 4'd0, 32'd0, 1'b0, 31'd0, 32'd0}},
      '{ROW_REQ, CSR_REPLACE_MODE, '0, KIND_FLUSH, 31'h2AAA_AAAA, 32'h5555_5555, 1'b1,
        NO_RESULT},
      '{ROW_REQ, CSR_REPLACE_MODE, '0, KIND_LOOKUP, KEY_MAX, '0, 1'b1, NO_RESULT},
      '{ROW_REQ, CSR_REPLACE_MODE, '0, KIND_INSERT, 31'h1234, 32'hDEAD_BEEF, 1'b1,
        '{1'b0, 4'd0, 32'd0, 1'b0, 31'd0, 32'd0}},
      '{ROW_CSR, CSR_REPLACE_MODE, 16'(MODE_LRU), KIND_LOOKUP, '0, '0, 1'b0, NO_RESULT},
      '{ROW_REQ, CSR_REPLACE_MODE, '0, KIND_INSERT, 31'h55, 32'hA5A5_A5A5, 1'b1,
        '{1'b0, 4'd1, 32'd0, 1'b0, 31'd0, 32'd0}},
      '{ROW_CSR, CSR_REPLACE_MODE, 16'(MODE_RANDOM), KIND_LOOKUP, '0, '0, 1'b0,
        NO_RESULT},
      '{ROW_CSR, CSR_RANDOM_SEED, SEED_ZERO, KIND_LOOKUP, '0, '0, 1'b0, NO_RESULT},
      '{ROW_REQ, CSR_REPLACE_MODE, '0, KIND_INSERT, 31'h66, 32'h1, 1'b1,
        '{1'b0, 4'd2, 32'd0, 1'b0, 31'd0, 32'd0}},
      '{ROW_CSR, CSR_REPLACE_MODE, 16'(MODE_LRU_ALIAS), KIND_LOOKUP, '0, '0, 1'b0,
        NO_RESULT},
      '{ROW_REQ, CSR_REPLACE_MODE, '0, KIND_INSERT, 31'h77, 32'h8000_0000, 1'b1,
        '{1'b0, 4'd3, 32'd0, 1'b0, 31'd0, 32'd0}},
      '{ROW_CSR, CSR_RANDOM_SEED, SEED_MAX, KIND_LOOKUP, '0, '0, 1'b0, NO_RESULT},
      '{ROW_CSR, CSR_REPLACE_MODE, 16'(MODE_FIFO), KIND_LOOKUP, '0, '0, 1'b0, NO_RESULT},
      '{ROW_REQ, CSR_REPLACE_MODE, '0, KIND_INSERT, 31'h88, 32'h7FFF_FFFF, 1'b0,
        NO_RESULT},
      '{ROW_REQ, CSR_REPLACE_MODE, '0, KIND_LOOKUP, 31'h1234, '0, 1'b0, NO_RESULT},
      '{ROW_REQ, CSR_REPLACE_MODE, '0, KIND_LOOKUP, 31'h55, '0, 1'b0, NO_RESULT}
   };

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       csr_write = 1'b0;
   logic [CSR_INDEX_BITS-1:0]  csr_index = '0;
   logic [CSR_DATA_BITS-1:0]   csr_data = '0;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [KIND_BITS-1:0]       req_kind = KIND_LOOKUP;
   logic [KEY_BITS-1:0]        req_key = '0;
   logic [OUT_HANDLE_BITS-1:0] req_handle = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic                       rsp_hit;
   logic [SLOT_BITS-1:0]       rsp_slot;
   logic [OUT_HANDLE_BITS-1:0] rsp_found_handle;
   logic                       rsp_evicted;
   logic [KEY_BITS-1:0]        rsp_evicted_key;
   logic [OUT_HANDLE_BITS-1:0] rsp_evicted_handle;

   // Model of the store.
   logic                       ent_valid  [NUM_ENTRIES];
   logic [KEY_BITS-1:0]        ent_key    [NUM_ENTRIES];
   logic [OUT_HANDLE_BITS-1:0] ent_handle [NUM_ENTRIES];
   int                         ent_rank   [NUM_ENTRIES];
   int                         fifo_next;
   logic [LFSR_BITS-1:0]       lfsr_state;
   logic [MODE_BITS-1:0]       repl_mode;

   cache_result_type results_due [$];

   int req_calm;
   int rsp_calm;
   int rsp_wait;
   int quiet_cycles;
   int mismatches;
   int results_seen;
   int lookups;
   int lookup_hits;
   int inserts;
   int evictions;
   int flushes;
   int unused_kinds;
   int csr_writes;

   assoc_cache_with_replacement #(
      .ENTRIES     (NUM_ENTRIES),
      .HANDLE_BITS (OUT_HANDLE_BITS)
   ) uut (
      .clock              (clock),
      .reset              (reset),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_kind           (req_kind),
      .req_key            (req_key),
      .req_handle         (req_handle),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_hit            (rsp_hit),
      .rsp_slot           (rsp_slot),
      .rsp_found_handle   (rsp_found_handle),
      .rsp_evicted        (rsp_evicted),
      .rsp_evicted_key    (rsp_evicted_key),
      .rsp_evicted_handle (rsp_evicted_handle)
   );

   always begin
      #(CLOCK_HALF) clock = 1'b1;
      #(CLOCK_HALF) clock = 0;
   end

   // Makes one entry the most recently used and closes the gap it leaves.
   function automatic void promote(input int idx);
      int old_rank;
      old_rank = ent_rank[idx];
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         if (ent_rank[i] > old_rank) ent_rank[i] = ent_rank[i] - 1;
      end
      ent_rank[idx] = NUM_ENTRIES - 1;
   endfunction

   // Applies one request to the model store and returns its response.
   function automatic cache_result_type cache_apply(input logic [KIND_BITS-1:0] kind,
         input logic [KEY_BITS-1:0] key, input logic [OUT_HANDLE_BITS-1:0] handle);
      cache_result_type res;
      int victim;
      res = '0;
      victim = -1;
      case (kind)
         KIND_LOOKUP: begin
            for (int i = 0; i < NUM_ENTRIES; i++) begin
               if (victim < 0 && ent_valid[i] && ent_key[i] == key) victim = i;
            end
            if (victim >= 0) begin
               promote(victim);
               res.hit = 1'b1;
               res.slot = SLOT_BITS'(victim);
               res.found_handle = ent_handle[victim];
            end
         end
         KIND_INSERT: begin
            if (repl_mode == MODE_FIFO) begin
               victim = fifo_next;
               fifo_next = (fifo_next + 1) % NUM_ENTRIES;
            end else begin
               for (int i = 0; i < NUM_ENTRIES; i++) begin
                  if (victim < 0 && !ent_valid[i]) victim = i;
               end
               if (victim < 0 && repl_mode == MODE_RANDOM) begin
                  lfsr_state = {lfsr_state[14:0],
                                lfsr_state[15] ^ lfsr_state[13] ^ lfsr_state[12] ^
                                lfsr_state[10]};
                  victim = int'(lfsr_state) % NUM_ENTRIES;
               end else if (victim < 0) begin
                  victim = 0;
                  for (int i = 1; i < NUM_ENTRIES; i++) begin
                     if (ent_rank[i] < ent_rank[victim]) victim = i;
                  end
               end
            end
            if (ent_valid[victim]) begin
               res.evicted = 1'b1;
               res.evicted_key = ent_key[victim];
               res.evicted_handle = ent_handle[victim];
            end
            ent_valid[victim] = 1'b1;
            ent_key[victim] = key;
            ent_handle[victim] = handle;
            promote(victim);
            res.slot = SLOT_BITS'(victim);
         end
         KIND_FLUSH: begin
            for (int i = 0; i < NUM_ENTRIES; i++) begin
               ent_valid[i] = 1'b0;
               ent_rank[i] = i;
            end
            fifo_next = 0;
         end
         default: ;
      endcase
      return res;
   endfunction

   // Wait drawn per item, with occasional stretches of back-to-back traffic.
   function automatic int draw_wait(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 39) == 0) begin
         calm = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 19);
   endfunction

   function automatic logic [KEY_BITS-1:0] fresh_key();
      case ($urandom_range(0, 15))
         0: return '0;
         1: return KEY_MAX;
         default: return KEY_BITS'($urandom);
      endcase
   endfunction

   function automatic logic [OUT_HANDLE_BITS-1:0] fresh_handle();
      case ($urandom_range(0, 15))
         0: return '0;
         1: return '1;
         default: return $urandom;
      endcase
   endfunction

   function automatic string show(input cache_result_type r);
      return $sformatf("hit=%0d slot=%0d found=%h evicted=%0d key=%h handle=%h",
                       r.hit, r.slot, r.found_handle, r.evicted, r.evicted_key,
                       r.evicted_handle);
   endfunction

   task automatic check_result(input cache_result_type seen);
      cache_result_type want;
      logic bad;
      results_seen++;
      if (results_due.size() == 0) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("ERROR: response with nothing outstanding: %s", show(seen));
      end else begin
         want = results_due.pop_front();
         bad = (seen.hit !== want.hit) || (seen.slot !== want.slot) ||
               (seen.found_handle !== want.found_handle) ||
               (seen.evicted !== want.evicted) ||
               (seen.evicted_key !== want.evicted_key) ||
               (seen.evicted_handle !== want.evicted_handle);
         if (bad) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("ERROR: response %0d mismatch at %0t", results_seen, $realtime);
               $display("   expected %s", show(want));
               $display("   actual   %s", show(seen));
            end
         end
      end
   endtask

   // One request transfer; the valid stays up when no gap follows.
   task automatic issue_request(input logic [KIND_BITS-1:0] kind,
         input logic [KEY_BITS-1:0] key, input logic [OUT_HANDLE_BITS-1:0] handle,
         input logic typed, input cache_result_type want);
      int gap;
      cache_result_type predicted;
      gap = draw_wait(req_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_kind   <= kind;
      req_key    <= key;
      req_handle <= handle;
      do @(posedge clock); while (req_stall);
      predicted = cache_apply(kind, key, handle);
      results_due.push_back(typed ? want : predicted);
      case (kind)
         KIND_LOOKUP: begin
            lookups++;
            lookup_hits += predicted.hit;
         end
         KIND_INSERT: begin
            inserts++;
            evictions += predicted.evicted;
         end
         KIND_FLUSH: flushes++;
         default: unused_kinds++;
      endcase
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (results_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register writes happen only with the store idle.
   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] sel,
         input logic [CSR_DATA_BITS-1:0] value);
      csr_write <= 1'b1;
      csr_index <= sel;
      csr_data  <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      if (sel == CSR_REPLACE_MODE) repl_mode = value[MODE_BITS-1:0];
      else lfsr_state = (value == SEED_ZERO) ? LFSR_ONE : value;
      csr_writes++;
      @(posedge clock);
   endtask

   // Mostly lookups of resident keys and inserts of new ones, so the store
   // fills up and replacement is exercised; flushes and unused kinds are rare.
   task automatic run_traffic(input int count);
      logic [KIND_BITS-1:0]       kind;
      logic [KEY_BITS-1:0]        key;
      logic [OUT_HANDLE_BITS-1:0] handle;
      int roll;
      int pick;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(0, 99);
         pick = $urandom_range(0, NUM_ENTRIES - 1);
         key = fresh_key();
         handle = fresh_handle();
         if (roll < 1) begin
            kind = KIND_FLUSH;
         end else if (roll < 3) begin
            kind = KIND_UNUSED;
         end else if (roll < 52) begin
            kind = KIND_LOOKUP;
            if (ent_valid[pick] && $urandom_range(0, 9) < 8) key = ent_key[pick];
         end else begin
            kind = KIND_INSERT;
            if (ent_valid[pick] && $urandom_range(0, 9) == 0) key = ent_key[pick];
         end
         issue_request(kind, key, handle, 1'b0, NO_RESULT);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_wait = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            check_result({rsp_hit, rsp_slot, rsp_found_handle, rsp_evicted,
                          rsp_evicted_key, rsp_evicted_handle});
            rsp_wait = draw_wait(rsp_calm);
         end
         if (rsp_wait > 0) begin
            rsp_stall <= 1'b1;
            rsp_wait--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("ERROR: no transfer for %0d cycles, %0d responses outstanding",
                  quiet_cycles, results_due.size());
         $display("assoc_cache_with_replacement test failed");
         $finish;
      end
   end

   initial begin
      logic [MODE_BITS-1:0] mode_pick;
      logic [LFSR_BITS-1:0] seed_pick;
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         ent_key[i] = '0;
         ent_handle[i] = '0;
      end
      void'(cache_apply(KIND_FLUSH, '0, '0));
      repl_mode = MODE_FIFO;
      lfsr_state = LFSR_RESET;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIRECTED_ROWS[r]) begin
         if (DIRECTED_ROWS[r].op == ROW_CSR) begin
            drain_results();
            write_register(DIRECTED_ROWS[r].csr_sel, DIRECTED_ROWS[r].csr_value);
         end else begin
            issue_request(DIRECTED_ROWS[r].kind, DIRECTED_ROWS[r].key,
                          DIRECTED_ROWS[r].handle, DIRECTED_ROWS[r].typed,
                          DIRECTED_ROWS[r].want);
         end
      end

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: begin
               mode_pick = MODE_RANDOM;
               seed_pick = SEED_ZERO;
            end
            1: begin
               mode_pick = MODE_RANDOM;
               seed_pick = SEED_MAX;
            end
            2: begin
               mode_pick = MODE_FIFO;
               seed_pick = LFSR_ONE;
            end
            3: begin
               mode_pick = MODE_LRU_ALIAS;
               seed_pick = LFSR_BITS'($urandom);
            end
            4: begin
               mode_pick = MODE_LRU;
               seed_pick = LFSR_BITS'($urandom);
            end
            default: begin
               mode_pick = MODE_BITS'($urandom_range(0, 3));
               seed_pick = ($urandom_range(0, 7) == 0) ? SEED_ZERO : LFSR_BITS'($urandom);
            end
         endcase
         drain_results();
         write_register(CSR_REPLACE_MODE, CSR_DATA_BITS'(mode_pick));
         write_register(CSR_RANDOM_SEED, seed_pick);
         run_traffic(PHASE_ITEMS);
      end

      drain_results();
      $display("Covered %0d lookups (%0d hits), %0d inserts (%0d evictions), %0d flushes,",
               lookups, lookup_hits, inserts, evictions, flushes);
      $display("%0d unused-kind requests and %0d register writes; %0d responses checked.",
               unused_kinds, csr_writes, results_seen);
      if (mismatches == 0 && results_due.size() == 0) begin
         $display("assoc_cache_with_replacement test passed");
      end else begin
         $display("assoc_cache_with_replacement test failed");
      end
      $finish;
   end

endmodule
